[rtl/core/mask_silhouette_profile_core_macros.svh]
// Assertion macros shared by the silhouette profile RTL.
`ifndef MASK_SILHOUETTE_PROFILE_CORE_MACROS_SVH
`define MASK_SILHOUETTE_PROFILE_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define MSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("silhouette profile check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define MSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("silhouette profile check failed");
`else
`define MSP_ASSERT_NOW(label, ante, cons)
`define MSP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/msp_pkg.sv]
// Shared constants and helpers for the mask silhouette profile core.
`timescale 1ns / 1ps
package msp_pkg;

  // Largest supported frame side in pixels.
  localparam int MaxDim  = 4096;
  // Bits of a column or row number.
  localparam int DimW    = $clog2(MaxDim);
  // Width of the size registers and of the configuration data.
  localparam int CfgW    = 13;
  localparam int CfgIdxW = 1;
  localparam int SumW    = 36;
  localparam int CountW  = 25;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;

  // Last valid coordinate for a programmed size: zero acts as one and
  // anything above the maximum is clamped to it.
  function automatic logic [DimW-1:0] last_index(input logic [CfgW-1:0] size);
    if (size == '0) begin
      return '0;
    end
    if (32'(size) > 32'(MaxDim)) begin
      return DimW'(MaxDim - 1);
    end
    return DimW'(size - 1'b1);
  endfunction

endpackage

[rtl/core/msp_pix_if.sv]
// Input channel carrying one mask pixel per word.
`timescale 1ns / 1ps
interface msp_pix_if;
  logic valid;
  logic ready;
  logic mask_bit;

  modport source (output valid, output mask_bit, input ready);
  modport sink (input valid, input mask_bit, output ready);
endinterface

[rtl/core/msp_res_if.sv]
// Result channel carrying one row extent, plus frame totals, per word.
`timescale 1ns / 1ps
interface msp_res_if;
  logic                        valid;
  logic                        ready;
  logic [msp_pkg::DimW-1:0]    row_y;
  logic [msp_pkg::DimW-1:0]    row_left;
  logic [msp_pkg::DimW-1:0]    row_right;
  logic                        row_present;
  logic                        frame_done;
  logic                        frame_ok;
  logic [msp_pkg::DimW-1:0]    box_min_x;
  logic [msp_pkg::DimW-1:0]    box_max_x;
  logic [msp_pkg::DimW-1:0]    box_min_y;
  logic [msp_pkg::DimW-1:0]    box_max_y;
  logic [msp_pkg::SumW-1:0]    row_sum;
  logic [msp_pkg::CountW-1:0]  fg_count;

  modport source (
    output valid, output row_y, output row_left, output row_right, output row_present,
    output frame_done, output frame_ok, output box_min_x, output box_max_x,
    output box_min_y, output box_max_y, output row_sum, output fg_count,
    input ready
  );
  modport sink (
    input valid, input row_y, input row_left, input row_right, input row_present,
    input frame_done, input frame_ok, input box_min_x, input box_max_x,
    input box_min_y, input box_max_y, input row_sum, input fg_count,
    output ready
  );
endinterface

[rtl/core/mask_silhouette_profile_core.sv]
// Streaming silhouette profile of a binary mask: row extents and frame box.
//
// The core takes one mask pixel word per clock in raster order and keeps the
// column and row position itself, so the frame size registers must match the
// stream. Every pixel is folded into running registers in the cycle it is
// accepted (a compare against the row and frame extremes, an increment of the
// foreground count and an add of the row number into the row sum), so the
// rate is one pixel per clock when not stalled. The last pixel of each row
// loads an output register, and its result word is offered on the next cycle;
// on the frame's last row that word also carries the bounding box, the row
// sum and the pixel count, and the frame state clears for the next frame.
// While a result word waits downstream, pixels that do not end a row are still
// taken; only a pixel that would end a row waits for the output register to
// free up. A size of zero acts as one and sizes above 4096 act as 4096. The
// size registers may be rewritten between pixels, and a row or frame ends as
// soon as the counter reaches or passes the new last index.
`timescale 1ns / 1ps
`include "mask_silhouette_profile_core_macros.svh"
module mask_silhouette_profile_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msp_pkg::CfgW-1:0]      cfg_data_i,
  msp_pix_if.sink                       pix_i,
  msp_res_if.source                     res_o
);

  localparam int DimW   = msp_pkg::DimW;
  localparam int CfgW   = msp_pkg::CfgW;
  localparam int SumW   = msp_pkg::SumW;
  localparam int CountW = msp_pkg::CountW;

  // Size registers.
  logic [CfgW-1:0] width_q;
  logic [CfgW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(640);
      height_q <= CfgW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msp_pkg::RegFrameWidth:  width_q  <= cfg_data_i;
        msp_pkg::RegFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Position and running statistics.
  logic [DimW-1:0]   col_q, col_d;
  logic [DimW-1:0]   row_q, row_d;
  logic [DimW-1:0]   cur_left_q, cur_left_d;
  logic [DimW-1:0]   cur_right_q, cur_right_d;
  logic              cur_seen_q, cur_seen_d;
  logic [DimW-1:0]   min_col_q, min_col_d;
  logic [DimW-1:0]   max_col_q, max_col_d;
  logic [DimW-1:0]   min_row_q, min_row_d;
  logic [DimW-1:0]   max_row_q, max_row_d;
  logic              any_seen_q, any_seen_d;
  logic [SumW-1:0]   accum_q, accum_d;
  logic [CountW-1:0] total_q, total_d;

  logic [DimW-1:0] col_last;
  logic [DimW-1:0] row_last;
  logic            row_end;
  logic            frame_end;
  logic            pix_fire;
  logic            res_fire;
  logic            fg;

  // Result register.
  logic              res_valid_q;
  logic [DimW-1:0]   res_row_y_q;
  logic [DimW-1:0]   res_left_q;
  logic [DimW-1:0]   res_right_q;
  logic              res_present_q;
  logic              res_done_q;
  logic              res_ok_q;
  logic [DimW-1:0]   res_min_x_q;
  logic [DimW-1:0]   res_max_x_q;
  logic [DimW-1:0]   res_min_y_q;
  logic [DimW-1:0]   res_max_y_q;
  logic [SumW-1:0]   res_sum_q;
  logic [CountW-1:0] res_count_q;

  assign col_last  = msp_pkg::last_index(width_q);
  assign row_last  = msp_pkg::last_index(height_q);
  assign row_end   = col_q >= col_last;
  assign frame_end = row_q >= row_last;
  assign fg        = pix_i.mask_bit;

  // A pixel that ends a row needs the output register to be free.
  assign pix_i.ready = !res_valid_q || res_o.ready || !row_end;
  assign pix_fire    = pix_i.valid && pix_i.ready;
  assign res_fire    = res_valid_q && res_o.ready;

  // Fold the current pixel into the running statistics.
  logic [DimW-1:0]   upd_left, upd_right;
  logic              upd_seen;
  logic [DimW-1:0]   upd_min_col, upd_max_col, upd_min_row, upd_max_row;
  logic              upd_any;
  logic [SumW-1:0]   upd_accum;
  logic [CountW-1:0] upd_total;

  always_comb begin
    upd_left    = cur_left_q;
    upd_right   = cur_right_q;
    upd_seen    = cur_seen_q;
    upd_min_col = min_col_q;
    upd_max_col = max_col_q;
    upd_min_row = min_row_q;
    upd_max_row = max_row_q;
    upd_any     = any_seen_q;
    upd_accum   = accum_q;
    upd_total   = total_q;
    if (fg) begin
      if (!cur_seen_q) begin
        upd_left  = col_q;
        upd_right = col_q;
      end else begin
        if (col_q < cur_left_q) upd_left = col_q;
        if (col_q > cur_right_q) upd_right = col_q;
      end
      upd_seen = 1'b1;
      if (!any_seen_q) begin
        upd_min_col = col_q;
        upd_max_col = col_q;
        upd_min_row = row_q;
        upd_max_row = row_q;
      end else begin
        if (col_q < min_col_q) upd_min_col = col_q;
        if (col_q > max_col_q) upd_max_col = col_q;
        if (row_q < min_row_q) upd_min_row = row_q;
        if (row_q > max_row_q) upd_max_row = row_q;
      end
      upd_any   = 1'b1;
      upd_accum = accum_q + SumW'(row_q);
      upd_total = total_q + CountW'(1);
    end
  end

  // Advance the position and clear row or frame state at the boundaries.
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    cur_left_d  = upd_left;
    cur_right_d = upd_right;
    cur_seen_d  = upd_seen;
    min_col_d   = upd_min_col;
    max_col_d   = upd_max_col;
    min_row_d   = upd_min_row;
    max_row_d   = upd_max_row;
    any_seen_d  = upd_any;
    accum_d     = upd_accum;
    total_d     = upd_total;
    if (!row_end) begin
      col_d = col_q + DimW'(1);
    end else begin
      col_d       = '0;
      cur_left_d  = '0;
      cur_right_d = '0;
      cur_seen_d  = 1'b0;
      if (frame_end) begin
        row_d      = '0;
        min_col_d  = '0;
        max_col_d  = '0;
        min_row_d  = '0;
        max_row_d  = '0;
        any_seen_d = 1'b0;
        accum_d    = '0;
        total_d    = '0;
      end else begin
        row_d = row_q + DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      cur_left_q  <= '0;
      cur_right_q <= '0;
      cur_seen_q  <= 1'b0;
      min_col_q   <= '0;
      max_col_q   <= '0;
      min_row_q   <= '0;
      max_row_q   <= '0;
      any_seen_q  <= 1'b0;
      accum_q     <= '0;
      total_q     <= '0;
    end else if (pix_fire) begin
      col_q       <= col_d;
      row_q       <= row_d;
      cur_left_q  <= cur_left_d;
      cur_right_q <= cur_right_d;
      cur_seen_q  <= cur_seen_d;
      min_col_q   <= min_col_d;
      max_col_q   <= max_col_d;
      min_row_q   <= min_row_d;
      max_row_q   <= max_row_d;
      any_seen_q  <= any_seen_d;
      accum_q     <= accum_d;
      total_q     <= total_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pix_fire && row_end) begin
      res_valid_q <= 1'b1;
    end else if (res_fire) begin
      res_valid_q <= 1'b0;
    end
  end

  // Output payload. Row fields are already zero for an empty row, and the
  // box fields are zero for an empty frame, since those registers clear.
  always_ff @(posedge clk_i) begin
    if (pix_fire && row_end) begin
      res_row_y_q   <= row_q;
      res_left_q    <= upd_left;
      res_right_q   <= upd_right;
      res_present_q <= upd_seen;
      res_done_q    <= frame_end;
      res_ok_q      <= frame_end && upd_any;
      res_min_x_q   <= frame_end ? upd_min_col : '0;
      res_max_x_q   <= frame_end ? upd_max_col : '0;
      res_min_y_q   <= frame_end ? upd_min_row : '0;
      res_max_y_q   <= frame_end ? upd_max_row : '0;
      res_sum_q     <= frame_end ? upd_accum : '0;
      res_count_q   <= frame_end ? upd_total : '0;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.row_y       = res_row_y_q;
  assign res_o.row_left    = res_left_q;
  assign res_o.row_right   = res_right_q;
  assign res_o.row_present = res_present_q;
  assign res_o.frame_done  = res_done_q;
  assign res_o.frame_ok    = res_ok_q;
  assign res_o.box_min_x   = res_min_x_q;
  assign res_o.box_max_x   = res_max_x_q;
  assign res_o.box_min_y   = res_min_y_q;
  assign res_o.box_max_y   = res_max_y_q;
  assign res_o.row_sum     = res_sum_q;
  assign res_o.fg_count    = res_count_q;

  // A row-ending pixel is only taken when the output register can load.
  `MSP_ASSERT_NOW(a_row_end_room, pix_fire && row_end, !res_valid_q || res_o.ready)
  // The frame's last pixel yields a frame word and leaves the position at origin.
  `MSP_ASSERT_NEXT(a_frame_wrap, pix_fire && row_end && frame_end, res_valid_q && res_done_q && col_q == '0 && row_q == '0)
  // A frame flagged as holding foreground is always the last row's word.
  `MSP_ASSERT_NOW(a_ok_on_done, res_valid_q && res_ok_q, res_done_q)

endmodule
